/* hdl/affine_vector_transform_defines.svh */
// Assertion macros used by the bound checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef AFFINE_VECTOR_TRANSFORM_DEFINES_SVH
`define AFFINE_VECTOR_TRANSFORM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/avt_pkg.sv */
`default_nettype none

package avt_pkg;

  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = 6;
  localparam int COORD_W   = 32;
  localparam int REG_W     = 64;

  localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

  typedef logic [REG_W-1:0] reg_word_t;
  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

  // Valid bits of the first three pipeline stages, used by the row units.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_vld_t;

endpackage

`default_nettype wire

/* hdl/avt_cfg.sv */
`default_nettype none

module avt_cfg #(
  parameter int FRAC_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [avt_pkg::ADDR_W-1:0]    paddr,
  input  wire  [avt_pkg::REG_W-1:0]     pwdata,
  output logic [avt_pkg::REG_W-1:0]     prdata,
  output logic                          pready,
  output avt_pkg::cfg_regs_t            regs
);
  import avt_pkg::*;

  localparam reg_word_t ONE = REG_W'(1) << FRAC_BITS;
  localparam cfg_regs_t RESET_REGS = {ONE, REG_W'(0), REG_W'(0), ONE << 32, REG_W'(0), ONE};

  logic [REG_IDX_W-1:0] idx;
  logic                 in_range;
  logic                 wr;

  assign idx      = paddr[ADDR_W-1:3];
  assign in_range = (idx <= REG_ROW2_COLS23);
  assign wr       = psel & penable & pwrite & pready;
  assign pready   = 1'b1;

  // Diagonal coefficients reset to one, everything else to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= RESET_REGS;
    end else if (wr && in_range) begin
      regs[idx] <= pwdata;
    end
  end

  always_comb begin
    if (in_range) begin
      prdata = regs[idx];
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

/* hdl/avt_row.sv */
`default_nettype none

module avt_row #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                 clk,
  input  avt_pkg::stage_vld_t                 vld,
  input  wire  signed [avt_pkg::COORD_W-1:0]  x,
  input  wire  signed [avt_pkg::COORD_W-1:0]  y,
  input  wire  signed [avt_pkg::COORD_W-1:0]  z,
  input  wire  signed [avt_pkg::COORD_W-1:0]  c0,
  input  wire  signed [avt_pkg::COORD_W-1:0]  c1,
  input  wire  signed [avt_pkg::COORD_W-1:0]  c2,
  input  wire         [avt_pkg::COORD_W-1:0]  t,
  output logic        [avt_pkg::COORD_W-1:0]  res
);
  import avt_pkg::*;

  logic signed [2*COORD_W-1:0] p0;
  logic signed [2*COORD_W-1:0] p1;
  logic signed [2*COORD_W-1:0] p2;
  logic        [COORD_W-1:0]   a01;
  logic        [COORD_W-1:0]   a2t;

  // Full signed products.
  always_ff @(posedge clk) begin
    if (vld.s1) begin
      p0 <= c0 * x;
      p1 <= c1 * y;
      p2 <= c2 * z;
    end
  end

  // Arithmetic shift and truncate is a slice of the product; add in pairs.
  always_ff @(posedge clk) begin
    if (vld.s2) begin
      a01 <= p0[FRAC_BITS+COORD_W-1:FRAC_BITS] + p1[FRAC_BITS+COORD_W-1:FRAC_BITS];
      a2t <= p2[FRAC_BITS+COORD_W-1:FRAC_BITS] + t;
    end
  end

  always_ff @(posedge clk) begin
    if (vld.s3) begin
      res <= a01 + a2t;
    end
  end

endmodule

`default_nettype wire

/* hdl/affine_vector_transform.sv */
// Affine transform of one 3D point per cycle, signed fixed point with
// FRAC_BITS fraction bits.
//
// Point channel: drive in_x, in_y, in_z with start high; the word is taken
// at the clock edge where start is high and busy is low. busy stays low, so
// a new point can be taken in every cycle.
// Result channel: done is high for one cycle with out_x, out_y, out_z. The
// receiver cannot stall; every result must be taken in its cycle.
// Pipeline: a taken point passes four register stages (input, products,
// pair sums, final sum) before its result shows on done.
// Throughput: one point per cycle, set by the fully pipelined multipliers.
// Configuration: six 64-bit coefficient registers on the APB port at byte
// address 8*i; the user writes only with no point in flight (unchecked).
// Reset (synchronous, rst high): coefficients return to identity and all
// points in flight are dropped.
`default_nettype none

module affine_vector_transform #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire  signed [avt_pkg::COORD_W-1:0]  in_x,
  input  wire  signed [avt_pkg::COORD_W-1:0]  in_y,
  input  wire  signed [avt_pkg::COORD_W-1:0]  in_z,
  output logic                                done,
  output logic signed [avt_pkg::COORD_W-1:0]  out_x,
  output logic signed [avt_pkg::COORD_W-1:0]  out_y,
  output logic signed [avt_pkg::COORD_W-1:0]  out_z,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire         [avt_pkg::ADDR_W-1:0]   paddr,
  input  wire         [avt_pkg::REG_W-1:0]    pwdata,
  output logic        [avt_pkg::REG_W-1:0]    prdata,
  output logic                                pready
);
  import avt_pkg::*;

  cfg_regs_t          regs;
  stage_vld_t         vld;
  logic               v4;
  logic               accept;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [COORD_W-1:0] pz;
  logic [COORD_W-1:0] rx;
  logic [COORD_W-1:0] ry;
  logic [COORD_W-1:0] rz;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v4  <= 1'b0;
    end else begin
      vld.s1 <= accept;
      vld.s2 <= vld.s1;
      vld.s3 <= vld.s2;
      v4     <= vld.s3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= in_x;
      py <= in_y;
      pz <= in_z;
    end
  end

  avt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  avt_row #(.FRAC_BITS(FRAC_BITS)) u_row0 (
    .clk (clk),
    .vld (vld),
    .x   (px),
    .y   (py),
    .z   (pz),
    .c0  (regs[REG_ROW0_COLS01][COORD_W-1:0]),
    .c1  (regs[REG_ROW0_COLS01][REG_W-1:COORD_W]),
    .c2  (regs[REG_ROW0_COLS23][COORD_W-1:0]),
    .t   (regs[REG_ROW0_COLS23][REG_W-1:COORD_W]),
    .res (rx)
  );

  avt_row #(.FRAC_BITS(FRAC_BITS)) u_row1 (
    .clk (clk),
    .vld (vld),
    .x   (px),
    .y   (py),
    .z   (pz),
    .c0  (regs[REG_ROW1_COLS01][COORD_W-1:0]),
    .c1  (regs[REG_ROW1_COLS01][REG_W-1:COORD_W]),
    .c2  (regs[REG_ROW1_COLS23][COORD_W-1:0]),
    .t   (regs[REG_ROW1_COLS23][REG_W-1:COORD_W]),
    .res (ry)
  );

  avt_row #(.FRAC_BITS(FRAC_BITS)) u_row2 (
    .clk (clk),
    .vld (vld),
    .x   (px),
    .y   (py),
    .z   (pz),
    .c0  (regs[REG_ROW2_COLS01][COORD_W-1:0]),
    .c1  (regs[REG_ROW2_COLS01][REG_W-1:COORD_W]),
    .c2  (regs[REG_ROW2_COLS23][COORD_W-1:0]),
    .t   (regs[REG_ROW2_COLS23][REG_W-1:COORD_W]),
    .res (rz)
  );

  assign done  = v4;
  assign out_x = rx;
  assign out_y = ry;
  assign out_z = rz;

endmodule

`default_nettype wire

/* hdl/avt_checker.sv */
`default_nettype none

`include "affine_vector_transform_defines.svh"

module avt_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                start,
  input wire                                busy,
  input wire                                done,
  input wire                                psel,
  input wire                                penable,
  input wire                                pwrite,
  input wire                                pready,
  input wire [avt_pkg::ADDR_W-1:0]          paddr,
  input wire [avt_pkg::REG_W-1:0]           pwdata,
  input wire [avt_pkg::REG_W-1:0]           prdata
);
  import avt_pkg::*;

  logic              acc;
  logic              wr_ok;
  logic              wr_seen;
  logic [ADDR_W-1:0] wr_addr;
  logic [REG_W-1:0]  wr_data;
  logic              rd_hit;

  assign acc   = start & ~busy;
  assign wr_ok = psel & penable & pwrite & pready & (paddr[ADDR_W-1:3] <= REG_ROW2_COLS23);

  // Hold the last write so a read of the same address in the next cycle can be checked.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_seen <= 1'b0;
    end else begin
      wr_seen <= wr_ok;
    end
    wr_addr <= paddr;
    wr_data <= pwdata;
  end

  assign rd_hit = wr_seen & psel & penable & ~pwrite & (paddr == wr_addr);

  `AVT_ASSERT_NEXT(a_latency, acc, ##3 done, "accepted word gave no result after four cycles")
  `AVT_ASSERT_NOW(a_no_phantom, done, $past(acc, 4), "result with no matching accepted word")
  `AVT_ASSERT_NOW(a_readback, rd_hit, prdata == wr_data, "readback differs from written word")

endmodule

bind affine_vector_transform avt_checker u_avt_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .pready  (pready),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata)
);

`default_nettype wire

/* tb/affine_vector_transform_checker.sv */
`default_nettype none

module affine_vector_transform_checker #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire                                busy,
  input  wire  [avt_pkg::COORD_W-1:0]        in_x,
  input  wire  [avt_pkg::COORD_W-1:0]        in_y,
  input  wire  [avt_pkg::COORD_W-1:0]        in_z,
  input  wire                                done,
  input  wire  [avt_pkg::COORD_W-1:0]        out_x,
  input  wire  [avt_pkg::COORD_W-1:0]        out_y,
  input  wire  [avt_pkg::COORD_W-1:0]        out_z,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire                                pready,
  input  wire  [avt_pkg::ADDR_W-1:0]         paddr,
  input  wire  [avt_pkg::REG_W-1:0]          pwdata,
  output int unsigned                        mismatches,
  output int unsigned                        in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  import avt_pkg::*;

  typedef logic [COORD_W-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  cfg_regs_t coef;
  point_t    expected_points[$];

  // Full signed product, arithmetic shift, keep the low word.
  function automatic coord_t fixed_mul(logic signed [COORD_W-1:0] a,
                                       logic signed [COORD_W-1:0] b);
    logic signed [2*COORD_W-1:0] prod;
    prod = a * b;
    return coord_t'(prod >>> FRAC_BITS);
  endfunction

  function automatic coord_t transform_row(reg_word_t c01, reg_word_t c23, point_t p);
    return fixed_mul(c01[COORD_W-1:0], p.x) + fixed_mul(c01[REG_W-1:COORD_W], p.y)
         + fixed_mul(c23[COORD_W-1:0], p.z) + c23[REG_W-1:COORD_W];
  endfunction

  function automatic point_t transform_point(cfg_regs_t regs, point_t p);
    point_t r;
    r.x = transform_row(regs[REG_ROW0_COLS01], regs[REG_ROW0_COLS23], p);
    r.y = transform_row(regs[REG_ROW1_COLS01], regs[REG_ROW1_COLS23], p);
    r.z = transform_row(regs[REG_ROW2_COLS01], regs[REG_ROW2_COLS23], p);
    return r;
  endfunction

  task automatic check_coord(string name, coord_t want, coord_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    logic [REG_IDX_W-1:0] idx;
    idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    if (rst) begin
      coef = '0;
      coef[REG_ROW0_COLS01] = reg_word_t'(1) << FRAC_BITS;
      coef[REG_ROW1_COLS01] = reg_word_t'(1) << (FRAC_BITS + COORD_W);
      coef[REG_ROW2_COLS23] = reg_word_t'(1) << FRAC_BITS;
      expected_points.delete();
    end else begin
      // writes to indexes past the last register are dropped
      if (psel && penable && pwrite && pready && idx < NUM_REGS)
        coef[idx] = pwdata;
      if (done) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, actual %h %h %h",
                   $time, out_x, out_y, out_z);
        end else begin
          want = expected_points.pop_front();
          check_coord("out_x", want.x, out_x);
          check_coord("out_y", want.y, out_y);
          check_coord("out_z", want.z, out_z);
        end
      end
      if (start && !busy)
        expected_points.push_back(transform_point(coef, point_t'({in_x, in_y, in_z})));
    end
    in_flight = expected_points.size();
  end

endmodule

`default_nettype wire

/* tb/affine_vector_transform_tb.sv */
`default_nettype none

module affine_vector_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import avt_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 750;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic [COORD_W-1:0] coord_t;

  localparam coord_t FIX_ONE   = coord_t'(1) << FRAC_BITS;
  localparam coord_t COORD_MAX = 32'h7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'h8000_0000;
  localparam coord_t ALL_ONES  = 32'hFFFF_FFFF;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  coord_t              in_x    = '0;
  coord_t              in_y    = '0;
  coord_t              in_z    = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [REG_W-1:0]    pwdata  = '0;
  logic                busy;
  logic                done;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [COORD_W-1:0]  out_z;
  logic [REG_W-1:0]    prdata;
  logic                pready;
  int unsigned         mismatches;
  int unsigned         in_flight;
  int unsigned         cycle_count = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  affine_vector_transform #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk, .rst, .start, .busy, .in_x, .in_y, .in_z, .done, .out_x, .out_y, .out_z,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  affine_vector_transform_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
    .clk, .rst, .start, .busy, .in_x, .in_y, .in_z, .done, .out_x, .out_y, .out_z,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .in_flight
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return COORD_MAX;
      2:       return COORD_MIN;
      3:       return ALL_ONES;
      4:       return FIX_ONE;
      5:       return -FIX_ONE;
      6, 7:    return coord_t'($urandom_range(0, 32 * FIX_ONE)) - 16 * FIX_ONE;
      default: return $urandom;
    endcase
  endfunction

  // Called and returns at a falling edge; gap is the count of idle cycles after the word.
  task automatic send_point(coord_t x, coord_t y, coord_t z, int gap);
    start <= 1'b1;
    in_x  <= x;
    in_y  <= y;
    in_z  <= z;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      in_x  <= $urandom;
      in_y  <= $urandom;
      in_z  <= $urandom;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold the point channel low until every result is back.
  task automatic wait_idle();
    start <= 1'b0;
    in_x  <= $urandom;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {(ADDR_W - REG_IDX_W){1'b0}}};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned sent;
    int          phase_len;
    int          idle_mode;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity coefficients straight out of reset
    send_point('0, '0, '0, 0);
    send_point(FIX_ONE, -FIX_ONE, ALL_ONES, 0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 0);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 3);
    send_point(32'h0000_0001, ALL_ONES, 32'h0001_8000, 0);
    send_point(32'hFFFF_8000, 32'h1234_5678, 32'hEDCB_A988, 1);
    wait_idle();

    // out of range indexes must leave the matrix alone
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, {32'h8000_0001, 32'h7FFF_0001});
    send_point(FIX_ONE, FIX_ONE, FIX_ONE, 0);
    send_point(COORD_MAX, ALL_ONES, COORD_MIN, 0);
    wait_idle();

    // extreme coefficients: product and sum overflow
    write_reg(REG_ROW0_COLS01, {COORD_MAX, COORD_MAX});
    write_reg(REG_ROW0_COLS23, {COORD_MAX, COORD_MAX});
    write_reg(REG_ROW1_COLS01, {COORD_MIN, COORD_MIN});
    write_reg(REG_ROW1_COLS23, {COORD_MIN, COORD_MIN});
    write_reg(REG_ROW2_COLS01, {ALL_ONES, COORD_MIN});
    write_reg(REG_ROW2_COLS23, {ALL_ONES, COORD_MAX});
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_point(COORD_MAX, COORD_MIN, '0, 0);
    send_point(ALL_ONES, ALL_ONES, ALL_ONES, 2);
    send_point(FIX_ONE, -FIX_ONE, 32'h0000_0001, 0);
    send_point('0, '0, '0, 0);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (int r = REG_ROW0_COLS01; r <= REG_ROW2_COLS23; r++)
        if ($urandom_range(0, 3) != 0)
          write_reg(r[REG_IDX_W-1:0], {pick_coord(), pick_coord()});
      if ($urandom_range(0, 4) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  {32'($urandom), 32'($urandom)});
      phase_len = $urandom_range(40, 120);
      idle_mode = $urandom_range(0, 2);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        send_point(pick_coord(), pick_coord(), pick_coord(),
                   idle_mode == 0 ? 0 : $urandom_range(0, 19));
        sent++;
        if ($urandom_range(0, 59) == 0)
          wait_idle();
      end
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (in_flight != 0)
        $display("%0t: %0d expected results never arrived", $time, in_flight);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
